@@ sv/mbpe_pkg.sv @@
// Package for the monochrome bitmap pixel expander: payload types and register indexes.
package mbpe_pkg;

	localparam int PixelBitsW = 7;
	localparam int ValueW     = 64;
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 64;
	localparam int ByteCntW   = 4;

	localparam logic [CfgIndexW-1:0] REG_PIXEL_BITS  = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_MARK_VALUE  = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_SPACE_VALUE = 2'd2;

	typedef struct packed {
		logic module_bit;
		logic row_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       row_done;
	} out_item_t;

endpackage

@@ sv/mono_bitmap_pixel_expander_unit.sv @@
// Top level of the monochrome bitmap pixel expander.
//
// Takes one bitmap module per transaction and emits the rendered bytes, one
// byte per output transaction. With pixel widths of 1, 2 or 4 bits a module
// yields a byte only when the byte fills or the row ends; with widths that
// are multiples of 8 a module yields 1 to 8 bytes and holds the byte emitter
// until its last byte is sent on, which output back-pressure can delay; only
// then is the next module loaded. The input register, the byte emitter and
// the output register each hold one item, so a new module is taken while
// earlier bytes still drain. Invalid widths swallow the module with no
// output. The user must write configuration only while the unit is idle;
// the unit does not enforce this. Writing pixel_bits discards any partly packed byte.
module mono_bitmap_pixel_expander_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mbpe_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mbpe_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [mbpe_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [mbpe_pkg::CfgDataW-1:0]       cfg_data
);

	// configuration registers
	logic [mbpe_pkg::PixelBitsW-1:0] pixel_bits_q;
	logic [mbpe_pkg::ValueW-1:0]     mark_value_q;
	logic [mbpe_pkg::ValueW-1:0]     space_value_q;

	// packing state
	logic [7:0] acc_q;
	logic [2:0] slots_q;

	// input stage
	logic              valid_s1;
	mbpe_pkg::in_item_t item_s1;

	// byte emitter
	logic [mbpe_pkg::ValueW-1:0]   emit_v_q;
	logic [mbpe_pkg::ByteCntW-1:0] emit_cnt_q;
	logic                          emit_end_q;

	// output register
	logic                out_valid_q;
	mbpe_pkg::out_item_t out_data_q;

	logic                          emitting;
	logic                          load;
	logic [mbpe_pkg::ValueW-1:0]   pix_v;
	logic                          is_packed;
	logic                          is_wide;
	logic [mbpe_pkg::ByteCntW-1:0] nbytes;
	logic [7:0]                    acc_new;
	logic [3:0]                    filled;
	logic [3:0]                    slots;
	logic [3:0]                    used_bits;
	logic [3:0]                    shamt;
	logic                          pack_flush;
	logic [7:0]                    pack_byte;

	// emitter hand-off
	assign emitting = (emit_cnt_q != '0) && (!out_valid_q || out_ready);
	assign load     = valid_s1 && ((emit_cnt_q == '0) ||
		((emit_cnt_q == mbpe_pkg::ByteCntW'(1)) && emitting));
	assign in_ready = !valid_s1 || load;

	// pixel value and width decode
	assign pix_v     = item_s1.module_bit ? mark_value_q : space_value_q;
	assign is_packed = (pixel_bits_q == 7'd1) || (pixel_bits_q == 7'd2) ||
		(pixel_bits_q == 7'd4);
	assign is_wide   = (pixel_bits_q[2:0] == 3'd0) && (pixel_bits_q[6:3] != 4'd0);
	assign nbytes    = pixel_bits_q[6] ? mbpe_pkg::ByteCntW'(8) : {1'b0, pixel_bits_q[5:3]};

	// packing of narrow pixels, newest pixel enters at the top
	always_comb begin
		case (pixel_bits_q[2:0])
			3'd1: begin
				acc_new   = {pix_v[0], acc_q[7:1]};
				slots     = 4'd8;
				used_bits = filled;
			end
			3'd2: begin
				acc_new   = {pix_v[1:0], acc_q[7:2]};
				slots     = 4'd4;
				used_bits = {filled[2:0], 1'b0};
			end
			3'd4: begin
				acc_new   = {pix_v[3:0], acc_q[7:4]};
				slots     = 4'd2;
				used_bits = {filled[1:0], 2'b00};
			end
			default: begin
				acc_new   = acc_q;
				slots     = 4'd8;
				used_bits = 4'd8;
			end
		endcase
	end

	assign filled     = {1'b0, slots_q} + 4'd1;
	assign pack_flush = (filled >= slots) || item_s1.row_end;
	assign shamt      = (filled >= slots) ? 4'd0 : 4'd8 - used_bits;
	assign pack_byte  = acc_new >> shamt;

	// configuration writes and packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bits_q  <= 7'd1;
			mark_value_q  <= 64'd1;
			space_value_q <= 64'd0;
			acc_q         <= '0;
			slots_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbpe_pkg::REG_PIXEL_BITS: begin
					pixel_bits_q <= cfg_data[mbpe_pkg::PixelBitsW-1:0];
					acc_q        <= '0;
					slots_q      <= '0;
				end
				mbpe_pkg::REG_MARK_VALUE:  mark_value_q  <= cfg_data;
				mbpe_pkg::REG_SPACE_VALUE: space_value_q <= cfg_data;
				default: ;
			endcase
		end else if (load && is_packed) begin
			if (pack_flush) begin
				acc_q   <= '0;
				slots_q <= '0;
			end else begin
				acc_q   <= acc_new;
				slots_q <= filled[2:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// byte emitter: holds the bytes still owed for one module
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
		end else if (load) begin
			if (is_packed) begin
				emit_cnt_q <= pack_flush ? mbpe_pkg::ByteCntW'(1) : '0;
			end else if (is_wide) begin
				emit_cnt_q <= nbytes;
			end else begin
				emit_cnt_q <= '0;
			end
		end else if (emitting) begin
			emit_cnt_q <= emit_cnt_q - mbpe_pkg::ByteCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			emit_v_q   <= is_packed ? {56'd0, pack_byte} : pix_v;
			emit_end_q <= item_s1.row_end;
		end else if (emitting) begin
			emit_v_q <= emit_v_q >> 8;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emitting) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emitting) begin
			out_data_q.out_byte <= emit_v_q[7:0];
			out_data_q.run_last <= (emit_cnt_q == mbpe_pkg::ByteCntW'(1));
			out_data_q.row_done <= (emit_cnt_q == mbpe_pkg::ByteCntW'(1)) && emit_end_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ bench/mbpe_render_checker.sv @@
// Checker for the pixel expander: predicts the rendered bytes and compares them on the output.
`timescale 1ns / 100ps

module mbpe_render_checker
	import mbpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	output int                   mismatches,
	output int                   bytes_owed
);

	// shadow of the registers and the packing state
	logic [PixelBitsW-1:0] px_width   = 7'd1;
	logic [ValueW-1:0]     mark_px    = 64'd1;
	logic [ValueW-1:0]     space_px   = 64'd0;
	logic [7:0]            pack_acc   = 8'd0;
	logic [2:0]            pack_count = 3'd0;

	out_item_t expected_bytes[$];
	int        error_count = 0;

	function automatic void owe_byte(input logic [7:0] value, input logic last, input logic done);
		out_item_t e;
		e.out_byte = value;
		e.run_last = last;
		e.row_done = done;
		expected_bytes.push_back(e);
	endfunction

	// bytes caused by one accepted module
	function automatic void render_module(input in_item_t it);
		logic [ValueW-1:0] px;
		logic [7:0]        acc;
		int                slots;
		int                filled;
		int                empty;
		int                nbytes;
		px = it.module_bit ? mark_px : space_px;
		case (px_width)
			7'd1, 7'd2, 7'd4: begin
				// newest pixel enters at the top, older ones move down
				slots  = 8 / px_width;
				acc    = (pack_acc >> px_width) | 8'(px << (8 - px_width));
				filled = pack_count + 1;
				if (filled >= slots || it.row_end) begin
					// partial byte at row end is right-aligned
					empty = (filled < slots) ? slots - filled : 0;
					owe_byte(acc >> (empty * px_width), 1'b1, it.row_end);
					pack_acc   = 8'd0;
					pack_count = 3'd0;
				end else begin
					pack_acc   = acc;
					pack_count = 3'(filled);
				end
			end
			default: begin
				// byte-multiple widths: little-endian, capped at eight bytes
				if (px_width >= 8 && px_width[2:0] == 3'b000) begin
					nbytes = px_width / 8;
					if (nbytes > 8)
						nbytes = 8;
					for (int k = 0; k < nbytes; k++) begin
						owe_byte(px[7:0], k == nbytes - 1, (k == nbytes - 1) && it.row_end);
						px = px >> 8;
					end
				end
				// anything else is swallowed
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_width   = 7'd1;
			mark_px    = 64'd1;
			space_px   = 64'd0;
			pack_acc   = 8'd0;
			pack_count = 3'd0;
			expected_bytes.delete();
		end else begin
			// register writes; a width write drops held pixels
			if (cfg_we) begin
				case (cfg_index)
					REG_PIXEL_BITS: begin
						px_width   = cfg_data[PixelBitsW-1:0];
						pack_acc   = 8'd0;
						pack_count = 3'd0;
					end
					REG_MARK_VALUE:  mark_px  = cfg_data;
					REG_SPACE_VALUE: space_px = cfg_data;
					default: ;
				endcase
			end

			// compare each output transaction with the oldest expected byte
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte %02h run_last %b row_done %b", $time,
						out_data.out_byte, out_data.run_last, out_data.row_done);
					error_count++;
				end else begin
					out_item_t e;
					e = expected_bytes.pop_front();
					if (out_data.out_byte !== e.out_byte) begin
						$display("%0t: out_byte expected %02h got %02h", $time,
							e.out_byte, out_data.out_byte);
						error_count++;
					end
					if (out_data.run_last !== e.run_last) begin
						$display("%0t: run_last expected %b got %b", $time,
							e.run_last, out_data.run_last);
						error_count++;
					end
					if (out_data.row_done !== e.row_done) begin
						$display("%0t: row_done expected %b got %b", $time,
							e.row_done, out_data.row_done);
						error_count++;
					end
				end
			end

			if (in_valid && in_ready)
				render_module(in_data);
		end
		mismatches <= error_count;
		bytes_owed <= expected_bytes.size();
	end

endmodule

@@ bench/mono_bitmap_pixel_expander_unit_tb.sv @@
// Testbench top for the pixel expander: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module mono_bitmap_pixel_expander_unit_tb;
	import mbpe_pkg::*;

	localparam int DrainCycles = 16;
	localparam int LongHold    = 300;
	localparam int CycleLimit  = 500000;
	localparam int RandomItems = 210;
	// index past the register list, written to check it is ignored
	localparam logic [CfgIndexW-1:0] REG_NONE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;
	logic                 hold_armed;
	int                   mismatches;
	int                   bytes_owed;
	int                   cycle_count = 0;

	mono_bitmap_pixel_expander_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mbpe_render_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.bytes_owed (bytes_owed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("mono_bitmap_pixel_expander_unit: mismatch");
			$finish;
		end
	end

	function automatic bit width_ok(input int pb);
		return pb == 1 || pb == 2 || pb == 4 || (pb >= 8 && pb % 8 == 0);
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic send_module(input logic mod_bit, input logic last_in_row);
		in_item_t it;
		int       gap;
		it.module_bit = mod_bit;
		it.row_end    = last_in_row;
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, wait for every owed byte, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (bytes_owed != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// width write with junk in the unused upper bits
	task automatic set_width(input int pb);
		logic [CfgDataW-1:0] value;
		value = {$urandom, $urandom};
		value[PixelBitsW-1:0] = PixelBitsW'(pb);
		write_reg(REG_PIXEL_BITS, value);
	endtask

	// output side: random stalls, plus one long hold-off when armed
	initial begin
		bit hold_taken;
		int r;
		int stall;
		hold_taken = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			r = $urandom_range(0, 99);
			stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 40);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		int counted;
		int phase;
		int pb;
		int n;
		int r;
		arst_n = 1'b0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_PIXEL_BITS;
		cfg_data   <= '0;
		hold_armed <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, one-bit pixels: partial byte at row end
		send_module(1'b1, 1'b0);
		send_module(1'b0, 1'b0);
		send_module(1'b1, 1'b1);
		drain();

		// two-bit pixels, values wider than a pixel: full byte, then one-pixel row
		set_width(2);
		write_reg(REG_MARK_VALUE, '1);
		write_reg(REG_SPACE_VALUE, 64'hFFFF_FFFF_FFFF_FFFA);
		send_module(1'b1, 1'b0);
		send_module(1'b0, 1'b0);
		send_module(1'b0, 1'b0);
		send_module(1'b1, 1'b0);
		send_module(1'b0, 1'b1);
		drain();

		// four-bit pixels: byte fills on the row end
		set_width(4);
		write_reg(REG_MARK_VALUE, '0);
		write_reg(REG_SPACE_VALUE, '1);
		send_module(1'b1, 1'b0);
		send_module(1'b0, 1'b1);
		drain();

		// widest plain pixel, eight bytes each
		set_width(64);
		write_reg(REG_MARK_VALUE, '1);
		write_reg(REG_SPACE_VALUE, 64'h0123_4567_89AB_CDEF);
		send_module(1'b0, 1'b0);
		send_module(1'b1, 1'b1);
		drain();

		// single byte, then a width above 64 that saturates
		set_width(8);
		send_module(1'b0, 1'b1);
		drain();
		set_width(120);
		send_module(1'b0, 1'b1);
		drain();

		// invalid widths swallow modules; stray index is ignored
		set_width(3);
		write_reg(REG_NONE, {$urandom, $urandom});
		send_module(1'b1, 1'b0);
		send_module(1'b0, 1'b1);
		drain();
		set_width(0);
		send_module(1'b1, 1'b1);
		drain();

		// rewriting the width drops pixels already held
		set_width(2);
		send_module(1'b1, 1'b0);
		send_module(1'b1, 1'b0);
		drain();
		set_width(2);
		send_module(1'b0, 1'b1);
		drain();

		// random phases with fresh settings each time
		counted = 0;
		phase   = 0;
		while (counted < RandomItems) begin
			if (phase == 0) begin
				// fill the unit against a long output hold-off
				pb = 64;
				hold_armed <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					pb = 1 << $urandom_range(0, 2);
				else if (r < 75)
					pb = 8 * $urandom_range(1, 8);
				else if (r < 85)
					pb = 8 * $urandom_range(9, 15);
				else
					do
						pb = $urandom_range(0, 127);
					while (width_ok(pb));
			end
			set_width(pb);
			write_reg(REG_MARK_VALUE, pick_value());
			write_reg(REG_SPACE_VALUE, pick_value());
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_NONE, {$urandom, $urandom});
			n = (phase == 0) ? 40 : $urandom_range(8, 30);
			for (int i = 0; i < n; i++) begin
				send_module(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
				counted++;
				// in phase 1, sender pause halfway through the modules until every byte is out
				if (phase == 1 && i == n / 2)
					drain();
			end
			drain();
			phase++;
		end

		if (mismatches == 0)
			$display("mono_bitmap_pixel_expander_unit: match");
		else
			$display("mono_bitmap_pixel_expander_unit: mismatch");
		$finish;
	end

endmodule
